// ===== rtl/srb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the system register block: window offsets,
// configuration register indexes and the mailbox access control group.
// ----------------------------------------------------------------------------
package srb_pkg;

  // Value read back from an empty mailbox slot or an undecoded offset.
  localparam logic [7:0] BLANK_BYTE = 8'hFF;

  // Offsets of the system register window.
  localparam logic [5:0] OFS_CTRL      = 6'h00;
  localparam logic [5:0] OFS_ADAPTER   = 6'h01;
  localparam logic [5:0] OFS_STBY_HI   = 6'h02;
  localparam logic [5:0] OFS_STBY_LO   = 6'h03;
  localparam logic [5:0] OFS_HCNT_HI   = 6'h04;
  localparam logic [5:0] OFS_HCNT_LO   = 6'h05;
  localparam logic [5:0] OFS_DCTL_HI   = 6'h06;
  localparam logic [5:0] OFS_DCTL_LO   = 6'h07;
  localparam logic [5:0] OFS_DSRC_FIRST = 6'h08;
  localparam logic [5:0] OFS_DSRC_LAST  = 6'h0B;
  localparam logic [5:0] OFS_DDST_FIRST = 6'h0C;
  localparam logic [5:0] OFS_DDST_LAST  = 6'h0F;
  localparam logic [5:0] OFS_DLEN_HI   = 6'h10;
  localparam logic [5:0] OFS_DLEN_LO   = 6'h11;
  localparam logic [5:0] OFS_FIFO_HI   = 6'h12;
  localparam logic [5:0] OFS_FIFO_LO   = 6'h13;
  localparam logic [5:0] OFS_IRQ_FIRST = 6'h14;
  localparam logic [5:0] OFS_IRQ_LAST  = 6'h1D;
  localparam logic [5:0] OFS_MB_FIRST  = 6'h20;
  localparam logic [5:0] OFS_MB_LAST   = 6'h2F;
  localparam logic [5:0] OFS_PWMC_HI   = 6'h30;
  localparam logic [5:0] OFS_PWMC_LO   = 6'h31;
  localparam logic [5:0] OFS_PCYC_HI   = 6'h32;
  localparam logic [5:0] OFS_PCYC_LO   = 6'h33;
  localparam logic [5:0] OFS_PW_FIRST  = 6'h34;
  localparam logic [5:0] OFS_PW_LAST   = 6'h39;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_ADAPTER_ENABLE = 3'd0,
    CFG_DREQ_CONTROL   = 3'd1,
    CFG_DREQ_SOURCE    = 3'd2,
    CFG_DREQ_DEST      = 3'd3,
    CFG_DREQ_LENGTH    = 3'd4
  } cfg_reg_t;

  // Access command of one item.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Mailbox access strobes for one accepted item.
  typedef struct packed {
    logic rd;
    logic wr;
  } mb_ctrl_t;

endpackage : srb_pkg
`default_nettype wire

// ===== rtl/system_register_block.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// system_register_block
// Byte-wide system register file of a two-CPU expansion unit.
// ----------------------------------------------------------------------------
// Each input transfer is one byte read or write; each produces exactly one
// result transfer carrying the read byte and an unsupported flag. The block
// takes one transfer per clock while the result is drained: the access is
// decoded, the state updated and the result registered at the acceptance
// edge. Input ready is high whenever that single output register is empty
// or being drained in the same cycle, so throughput is one item per cycle
// while m_tready is high. The mailbox is a store with a registered read
// port and per-slot written marks, so no clearing pass runs after reset.
// Configuration writes are taken at any edge with cfg_we high and rst low.
// ----------------------------------------------------------------------------
module system_register_block #(
  parameter int MAILBOX_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Access stream in.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // address[5:0], write_byte[13:6], fifo_word[29:14]
  input  wire logic [1:0]  s_tuser,   // cmd[0], from_master[1]
  // Result stream out.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // read_data[7:0]
  output logic             m_tuser    // unsupported[0]
);
  import srb_pkg::*;

  localparam int IDX_W = (MAILBOX_BYTES > 1) ? $clog2(MAILBOX_BYTES) : 1;

  // Configuration registers.
  logic        adapter_enable;
  logic [15:0] dreq_control;
  logic [31:0] dreq_source;
  logic [31:0] dreq_dest;
  logic [15:0] dreq_length;

  // Register file state.
  logic        fm_bit;
  logic [7:0]  master_adapter_byte;
  logic [7:0]  slave_adapter_byte;
  logic [15:0] standby_word;
  logic [15:0] hcount_word;
  logic [15:0] irq_clear_words [5];
  logic [15:0] pwm_control_word;
  logic [15:0] pwm_cycle_word;
  logic [15:0] pulse_width_words [3];
  logic [15:0] fifo_latch;

  // Result register.
  logic [7:0]  res_byte;
  logic        res_bad;
  logic        res_mb;

  // Unpacked item fields.
  logic [5:0]  addr;
  logic [7:0]  wbyte;
  logic [15:0] fifo;
  logic        cmd;
  logic        master;
  logic        accept;

  logic        mb_hit;
  logic [IDX_W-1:0] mb_idx;
  mb_ctrl_t    mb_ctrl;
  logic [7:0]  mb_rdata;
  logic [2:0]  irq_k;
  logic [1:0]  pw_k;
  logic [7:0]  rd_byte;
  logic        bad;

  function automatic logic [7:0] byte_of16(input logic [15:0] w, input logic lo);
    return lo ? w[7:0] : w[15:8];
  endfunction

  // Most significant byte at the lowest offset of the group.
  function automatic logic [7:0] byte_of32(input logic [31:0] w, input logic [1:0] sel);
    logic [7:0] b;
    case (sel)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  assign addr   = s_tdata[5:0];
  assign wbyte  = s_tdata[13:6];
  assign fifo   = s_tdata[29:14];
  assign cmd    = s_tuser[0];
  assign master = s_tuser[1];

  // One result slot: take a new item when it is empty or drains now.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Mailbox window decode; slots past the configured size are undecoded.
  assign mb_hit = (addr[5:4] == OFS_MB_FIRST[5:4]) && (32'(addr[3:0]) < MAILBOX_BYTES);
  assign mb_idx = IDX_W'(addr[3:0]);
  assign mb_ctrl.rd = accept && (cmd == CMD_READ) && mb_hit;
  assign mb_ctrl.wr = accept && (cmd == CMD_WRITE) && mb_hit;

  // Word selectors inside the interrupt-clear and pulse-width groups.
  assign irq_k = 3'((addr - OFS_IRQ_FIRST) >> 1);
  assign pw_k  = addr[2:1] + 2'd2;

  // Read data and decode status of the current item.
  always_comb begin
    rd_byte = BLANK_BYTE;
    bad     = 1'b0;
    case (addr) inside
      OFS_CTRL:    rd_byte = {fm_bit, 5'b0, adapter_enable, 1'b0};
      OFS_ADAPTER: rd_byte = master ? master_adapter_byte : slave_adapter_byte;
      OFS_STBY_HI, OFS_STBY_LO, [OFS_IRQ_FIRST:OFS_IRQ_LAST]: rd_byte = BLANK_BYTE;
      OFS_HCNT_HI, OFS_HCNT_LO: rd_byte = byte_of16(hcount_word, addr[0]);
      OFS_DCTL_HI, OFS_DCTL_LO: rd_byte = byte_of16(dreq_control, addr[0]);
      [OFS_DSRC_FIRST:OFS_DSRC_LAST]: rd_byte = byte_of32(dreq_source, addr[1:0]);
      [OFS_DDST_FIRST:OFS_DDST_LAST]: rd_byte = byte_of32(dreq_dest, addr[1:0]);
      OFS_DLEN_HI, OFS_DLEN_LO: rd_byte = byte_of16(dreq_length, addr[0]);
      OFS_FIFO_HI: rd_byte = fifo[15:8];
      OFS_FIFO_LO: rd_byte = fifo_latch[7:0];
      [OFS_MB_FIRST:OFS_MB_LAST]: bad = !mb_hit;
      OFS_PWMC_HI, OFS_PWMC_LO: rd_byte = byte_of16(pwm_control_word, addr[0]);
      OFS_PCYC_HI, OFS_PCYC_LO: rd_byte = byte_of16(pwm_cycle_word, addr[0]);
      [OFS_PW_FIRST:OFS_PW_LAST]: begin
        rd_byte = addr[0] ? 8'h00 : {pulse_width_words[pw_k][15:14], 6'b0};
      end
      default: bad = 1'b1;
    endcase
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      adapter_enable <= 1'b0;
      dreq_control   <= '0;
      dreq_source    <= '0;
      dreq_dest      <= '0;
      dreq_length    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ADAPTER_ENABLE: adapter_enable <= cfg_data[0];
        CFG_DREQ_CONTROL:   dreq_control   <= cfg_data[15:0];
        CFG_DREQ_SOURCE:    dreq_source    <= cfg_data;
        CFG_DREQ_DEST:      dreq_dest      <= cfg_data;
        CFG_DREQ_LENGTH:    dreq_length    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Register file updates from accepted writes, and the FIFO latch on reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      fm_bit              <= 1'b0;
      master_adapter_byte <= '0;
      slave_adapter_byte  <= '0;
      standby_word        <= '0;
      hcount_word         <= '0;
      irq_clear_words     <= '{default: '0};
      pwm_control_word    <= '0;
      pwm_cycle_word      <= '0;
      pulse_width_words   <= '{default: '0};
      fifo_latch          <= '0;
    end else if (accept && (cmd == CMD_READ)) begin
      if (addr == OFS_FIFO_HI) begin
        fifo_latch <= fifo;
      end
    end else if (accept) begin
      case (addr) inside
        OFS_CTRL: fm_bit <= wbyte[7];
        OFS_ADAPTER: begin
          // Bit 7 written by one CPU shows up in the other CPU's byte.
          if (master) begin
            master_adapter_byte <= wbyte;
            slave_adapter_byte  <= {wbyte[7], slave_adapter_byte[6:0]};
          end else begin
            slave_adapter_byte  <= wbyte;
            master_adapter_byte <= {wbyte[7], master_adapter_byte[6:0]};
          end
        end
        OFS_STBY_HI: standby_word[15:8] <= wbyte;
        OFS_STBY_LO: standby_word[7:0]  <= wbyte;
        OFS_HCNT_HI: hcount_word[15:8]  <= wbyte;
        OFS_HCNT_LO: hcount_word[7:0]   <= wbyte;
        [OFS_IRQ_FIRST:OFS_IRQ_LAST]: begin
          if (addr[0]) begin
            irq_clear_words[irq_k][7:0] <= wbyte;
          end else begin
            irq_clear_words[irq_k][15:8] <= wbyte;
          end
        end
        OFS_PWMC_HI: pwm_control_word[15:8] <= wbyte;
        OFS_PWMC_LO: pwm_control_word[7:0]  <= wbyte;
        OFS_PCYC_HI: pwm_cycle_word[15:8]   <= wbyte;
        OFS_PCYC_LO: pwm_cycle_word[7:0]    <= wbyte;
        [OFS_PW_FIRST:OFS_PW_LAST]: begin
          // The high byte keeps only six bits of the written value.
          if (addr[0]) begin
            pulse_width_words[pw_k][7:0] <= wbyte;
          end else begin
            pulse_width_words[pw_k][13:8] <= wbyte[5:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_bad  <= bad;
      res_mb   <= mb_ctrl.rd;
      res_byte <= (cmd == CMD_WRITE) ? 8'h00 : rd_byte;
    end
  end

  srb_mailbox #(
    .DEPTH (MAILBOX_BYTES)
  ) u_mailbox (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (mb_ctrl),
    .idx   (mb_idx),
    .wdata (wbyte),
    .rdata (mb_rdata)
  );

  assign m_tdata = res_mb ? mb_rdata : res_byte;
  assign m_tuser = res_bad;

endmodule : system_register_block
`default_nettype wire

// ===== rtl/srb_mailbox.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srb_mailbox
// Mailbox byte store shared by both CPUs. The read data is registered and
// holds until the next read. Slots never written read as 0xFF.
// ----------------------------------------------------------------------------
module srb_mailbox #(
  parameter int DEPTH = 16,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire srb_pkg::mb_ctrl_t ctrl,
  input  wire logic [IDX_W-1:0] idx,
  input  wire logic [7:0]       wdata,
  output logic      [7:0]       rdata
);
  import srb_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [7:0]       mem_q;
  logic             valid_q;

  // Storage array write port.
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[idx] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      mem_q   <= mem[idx];
      valid_q <= valid[idx];
    end
  end

  // Written-slot marks; reset makes every slot read as blank.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctrl.wr) begin
      valid[idx] <= 1'b1;
    end
  end

  assign rdata = valid_q ? mem_q : BLANK_BYTE;

endmodule : srb_mailbox
`default_nettype wire
